### src/sllm_pkg.sv
// ----------------------------------------------------------------------------
// sllm_pkg
// Shared types and codes of the static linked list manager.
// ----------------------------------------------------------------------------
package sllm_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned SlotWidth  = 7;
  localparam int unsigned CountWidth = 8;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    op_t                          op;
    logic signed [ValueWidth-1:0] value;
  } in_t;

  typedef struct packed {
    status_t               status;
    logic [SlotWidth-1:0]  slot;
    logic [CountWidth-1:0] element_count;
  } out_t;

endpackage

### src/static_linked_list_manager_top.sv
// ----------------------------------------------------------------------------
// static_linked_list_manager_top
// Singly linked list in a fixed node store with a separate free list.
// ----------------------------------------------------------------------------
// Usage: drive in_data and raise start; the command transfers at the rising
// edge where start is high and busy is low. OP_APPEND takes the free head
// node, stores the value and links it after the tail. OP_DELETE walks the
// list from its first node and frees the first node holding the value.
// Every command gives exactly one result, shown on out_data for one cycle
// with out_valid high; the receiver cannot stall it.
// An append passes through the write and link states; an append on a full
// store and a delete on an empty list are answered straight from idle. A
// delete compares nodes until a match, which then passes through the free
// state, or until the list ends. The walk reads one node per cycle through
// the value and link memories (one synchronous read each).
// Commands are processed one at a time; busy stays high until the result
// is issued, and a new command may be taken in the result cycle.
// Reset empties the list and frees every node at once: a fill mark stands
// in for the initial link chain, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module static_linked_list_manager_top #(
  parameter int unsigned NODE_COUNT = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sllm_pkg::in_t in_data,
  output logic          out_valid,
  output sllm_pkg::out_t out_data
);
  import sllm_pkg::*;

  localparam int unsigned SW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned PW = SW + 1;              // slot pointer incl. null
  localparam logic [PW-1:0] NullSlot = PW'(NODE_COUNT);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_A_WR   = 5'b00010,
    S_A_LINK = 5'b00100,
    S_D_CMP  = 5'b01000,
    S_D_FREE = 5'b10000
  } state_t;

  // node store
  logic [ValueWidth-1:0] val_mem  [NODE_COUNT];
  logic [PW-1:0]         link_mem [NODE_COUNT];

  state_t                state_r, state_nxt;
  logic [PW-1:0]         free_r, free_nxt;
  logic [PW-1:0]         first_r, first_nxt;
  logic [PW-1:0]         last_r, last_nxt;
  logic [PW-1:0]         cnt_r, cnt_nxt;
  logic [PW-1:0]         fill_r, fill_nxt;   // slots at or above this were never linked
  logic [PW-1:0]         cur_r, cur_nxt;
  logic [PW-1:0]         prev_r, prev_nxt;
  logic [ValueWidth-1:0] key_r, key_nxt;
  logic                  out_vld_r, out_vld_nxt;
  out_t                  out_r, out_nxt;

  logic                  rd_en;
  logic [PW-1:0]         rd_addr;
  logic [ValueWidth-1:0] val_q;
  logic [PW-1:0]         link_q;
  logic                  fresh_r;
  logic [PW-1:0]         seq_r;
  logic [PW-1:0]         link_rd;

  logic                  val_we;
  logic [PW-1:0]         val_wa;
  logic                  link_we;
  logic [PW-1:0]         link_wa;
  logic [PW-1:0]         link_wd;

  logic                  accept;
  logic [SW+SlotWidth-1:0]  slot_wide;
  logic [PW+CountWidth-1:0] cnt_wide;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // memories: synchronous read, one write port each
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa[SW-1:0]] <= key_r;
    end
    if (rd_en) begin
      val_q <= val_mem[rd_addr[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa[SW-1:0]] <= link_wd;
    end
    if (rd_en) begin
      link_q  <= link_mem[rd_addr[SW-1:0]];
      fresh_r <= (rd_addr >= fill_r);
      seq_r   <= rd_addr + PW'(1);
    end
  end

  // a never-linked slot reads as if it held its reset link to the next slot
  assign link_rd = fresh_r ? seq_r : link_q;

  always_comb begin
    state_nxt   = state_r;
    free_nxt    = free_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    cnt_nxt     = cnt_r;
    fill_nxt    = fill_r;
    cur_nxt     = cur_r;
    prev_nxt    = prev_r;
    key_nxt     = key_r;
    out_vld_nxt = 1'b0;
    out_nxt     = out_r;
    rd_en       = 1'b0;
    rd_addr     = cur_r;
    val_we      = 1'b0;
    val_wa      = cur_r;
    link_we     = 1'b0;
    link_wa     = cur_r;
    link_wd     = NullSlot;
    slot_wide   = {{SlotWidth{1'b0}}, cur_r[SW-1:0]};
    cnt_wide    = {{CountWidth{1'b0}}, cnt_r};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt = in_data.value;
          if (in_data.op == OP_APPEND) begin
            if (free_r == NullSlot) begin
              out_vld_nxt           = 1'b1;
              out_nxt.status        = ST_FULL;
              out_nxt.slot          = '0;
              out_nxt.element_count = cnt_wide[CountWidth-1:0];
            end else begin
              rd_en     = 1'b1;
              rd_addr   = free_r;
              cur_nxt   = free_r;
              state_nxt = S_A_WR;
            end
          end else begin
            if (first_r == NullSlot) begin
              out_vld_nxt           = 1'b1;
              out_nxt.status        = ST_NOT_FOUND;
              out_nxt.slot          = '0;
              out_nxt.element_count = cnt_wide[CountWidth-1:0];
            end else begin
              rd_en     = 1'b1;
              rd_addr   = first_r;
              cur_nxt   = first_r;
              prev_nxt  = NullSlot;
              state_nxt = S_D_CMP;
            end
          end
        end
      end

      S_A_WR: begin
        val_we    = 1'b1;
        val_wa    = cur_r;
        link_we   = 1'b1;
        link_wa   = cur_r;
        link_wd   = NullSlot;
        free_nxt  = link_rd;
        if (cur_r == fill_r) begin
          fill_nxt = fill_r + PW'(1);
        end
        state_nxt = S_A_LINK;
      end

      S_A_LINK: begin
        if (last_r != NullSlot) begin
          link_we = 1'b1;
          link_wa = last_r;
          link_wd = cur_r;
        end else begin
          first_nxt = cur_r;
        end
        last_nxt              = cur_r;
        cnt_nxt               = cnt_r + PW'(1);
        cnt_wide              = {{CountWidth{1'b0}}, cnt_nxt};
        out_vld_nxt           = 1'b1;
        out_nxt.status        = ST_DONE;
        out_nxt.slot          = slot_wide[SlotWidth-1:0];
        out_nxt.element_count = cnt_wide[CountWidth-1:0];
        state_nxt             = S_IDLE;
      end

      S_D_CMP: begin
        if (val_q == key_r) begin
          // unlink: predecessor (or list head) skips the matched node
          if (prev_r != NullSlot) begin
            link_we = 1'b1;
            link_wa = prev_r;
            link_wd = link_rd;
          end else begin
            first_nxt = link_rd;
          end
          if (last_r == cur_r) begin
            last_nxt = prev_r;
          end
          state_nxt = S_D_FREE;
        end else if (link_rd == NullSlot) begin
          out_vld_nxt           = 1'b1;
          out_nxt.status        = ST_NOT_FOUND;
          out_nxt.slot          = '0;
          out_nxt.element_count = cnt_wide[CountWidth-1:0];
          state_nxt             = S_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = link_rd;
          prev_nxt = cur_r;
          cur_nxt  = link_rd;
        end
      end

      S_D_FREE: begin
        link_we  = 1'b1;
        link_wa  = cur_r;
        link_wd  = free_r;
        free_nxt = cur_r;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - PW'(1);
        end
        cnt_wide              = {{CountWidth{1'b0}}, cnt_nxt};
        out_vld_nxt           = 1'b1;
        out_nxt.status        = ST_DONE;
        out_nxt.slot          = slot_wide[SlotWidth-1:0];
        out_nxt.element_count = cnt_wide[CountWidth-1:0];
        state_nxt             = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      free_r    <= '0;
      first_r   <= NullSlot;
      last_r    <= NullSlot;
      cnt_r     <= '0;
      fill_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      free_r    <= free_nxt;
      first_r   <= first_nxt;
      last_r    <= last_nxt;
      cnt_r     <= cnt_nxt;
      fill_r    <= fill_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    key_r  <= key_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

### src/sllm_checker.sv
// ----------------------------------------------------------------------------
// sllm_checker
// Port-level checks of the static linked list manager, bound to the top.
// ----------------------------------------------------------------------------
module sllm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input sllm_pkg::out_t out_data
);
  import sllm_pkg::*;

  // every accepted command is either answered next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command neither answered nor in progress");

  // leaving busy always comes with the command's result
  a_done_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // no result while a command is still in progress
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result issued while busy");

  // failed commands report slot zero
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_DONE) |-> (out_data.slot == '0))
    else $error("failed command reports a nonzero slot");

endmodule

bind static_linked_list_manager_top sllm_checker u_sllm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

### verif/static_linked_list_manager_top_tb.sv
// ----------------------------------------------------------------------------
// static_linked_list_manager_top_tb
// Self-checking bench for the linked list manager: a scoreboard keeps its own
// node store, free list and list pointers, predicts one result per command
// and checks every out_valid transfer against it in order. Stimulus is a
// short directed list followed by random fill, drain and mixed runs, with
// the command side idling at several rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module static_linked_list_manager_top_tb;
  import sllm_pkg::*;

  localparam int unsigned NODE_COUNT  = 128;
  localparam int unsigned NULL_SLOT   = NODE_COUNT;
  localparam int unsigned ItemTarget  = 1450;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned MaxReported = 30;

  class list_scoreboard;
    logic [ValueWidth-1:0] node_value [NODE_COUNT];
    logic [7:0]            node_link  [NODE_COUNT];
    logic [7:0]            free_head;
    logic [7:0]            first_slot;
    logic [7:0]            last_slot;
    int unsigned           used_count;
    out_t                  expected_results [$];
    int unsigned           mismatches;
    int unsigned           checked;
    int unsigned           n_appended, n_full, n_removed, n_missed;

    function new();
      for (int i = 0; i < NODE_COUNT; i++) begin
        node_value[i] = '0;
        node_link[i]  = 8'(i + 1);
      end
      free_head   = '0;
      first_slot  = 8'(NULL_SLOT);
      last_slot   = 8'(NULL_SLOT);
      used_count  = 0;
      mismatches  = 0;
      checked     = 0;
      n_appended  = 0;
      n_full      = 0;
      n_removed   = 0;
      n_missed    = 0;
    endfunction

    task report(string msg);
      if (mismatches < MaxReported) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // value held by the k-th list node, in list order
    function automatic logic [ValueWidth-1:0] nth_value(int unsigned k);
      logic [7:0] cur;
      cur = first_slot;
      for (int unsigned i = 0; i < k && cur < NULL_SLOT; i++) cur = node_link[cur[6:0]];
      return node_value[cur[6:0]];
    endfunction

    function automatic out_t apply_command(in_t cmd);
      out_t       r;
      logic [7:0] cur, prev;
      int         steps;
      r.status = ST_NOT_FOUND;
      r.slot   = '0;
      if (cmd.op == OP_APPEND) begin
        if (free_head >= NULL_SLOT) begin
          r.status = ST_FULL;
        end else begin
          cur = free_head;
          free_head = node_link[cur[6:0]];
          node_value[cur[6:0]] = cmd.value;
          node_link[cur[6:0]] = 8'(NULL_SLOT);
          if (last_slot < NULL_SLOT) node_link[last_slot[6:0]] = cur;
          else first_slot = cur;
          last_slot = cur;
          used_count++;
          r.status = ST_DONE;
          r.slot = cur[6:0];
        end
      end else begin
        prev  = 8'(NULL_SLOT);
        cur   = first_slot;
        steps = 0;
        while (steps < NODE_COUNT && cur < NULL_SLOT && r.status != ST_DONE) begin
          if (node_value[cur[6:0]] == cmd.value) begin
            // unlink, then push the node onto the free list
            if (prev < NULL_SLOT) node_link[prev[6:0]] = node_link[cur[6:0]];
            else first_slot = node_link[cur[6:0]];
            if (last_slot == cur) last_slot = prev;
            node_link[cur[6:0]] = free_head;
            free_head = cur;
            if (used_count > 0) used_count--;
            r.status = ST_DONE;
            r.slot = cur[6:0];
          end else begin
            prev = cur;
            cur  = node_link[cur[6:0]];
          end
          steps++;
        end
      end
      r.element_count = used_count[CountWidth-1:0];
      return r;
    endfunction

    function void note_command(in_t cmd);
      out_t r;
      r = apply_command(cmd);
      expected_results.push_back(r);
      if (cmd.op == OP_APPEND) begin
        if (r.status == ST_DONE) n_appended++;
        else n_full++;
      end else begin
        if (r.status == ST_DONE) n_removed++;
        else n_missed++;
      end
    endfunction

    task check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result %p with no command pending", got));
      end else begin
        want = expected_results.pop_front();
        checked++;
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.slot !== want.slot)
          report($sformatf("slot got %0d want %0d", got.slot, want.slot));
        if (got.element_count !== want.element_count)
          report($sformatf("element_count got %0d want %0d",
                           got.element_count, want.element_count));
      end
    endtask
  endclass

  logic  clk = 1'b0;
  logic  rst_n;
  logic  start;
  logic  busy;
  in_t   in_data;
  logic  out_valid;
  out_t  out_data;

  list_scoreboard sb;
  int unsigned    sent;
  int unsigned    gap_pct;
  int unsigned    idle_cycles;

  static_linked_list_manager_top #(
    .NODE_COUNT(NODE_COUNT)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // start stays high after a transfer; the next call decides at the falling edge
  task automatic send_cmd(op_t op, logic [ValueWidth-1:0] v);
    in_t cmd;
    cmd.op    = op;
    cmd.value = v;
    @(negedge clk);
    while (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      start   <= 1'b0;
      in_data <= in_t'({$urandom, $urandom});
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
    sb.note_command(cmd);
    sent++;
  endtask

  function automatic logic [ValueWidth-1:0] pick_value();
    logic [ValueWidth-1:0] v;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: v = ValueWidth'($signed($urandom_range(6, 0)) - 3);
      4: begin
        case ($urandom_range(3, 0))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          default: v = '0;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic void set_phase();
    case (sent * 4 / ItemTarget)
      0: gap_pct = 0;
      1: gap_pct = 65;
      2: gap_pct = 19;
      default: gap_pct = 0;
    endcase
  endfunction

  task automatic fill_store();
    while (sb.used_count < NODE_COUNT && sent < ItemTarget) begin
      set_phase();
      send_cmd(OP_APPEND, pick_value());
    end
    repeat ($urandom_range(3, 1)) send_cmd(OP_APPEND, pick_value());
  endtask

  task automatic drain_list();
    int unsigned keep;
    keep = $urandom_range(sb.used_count / 2, 0);
    while (sb.used_count > keep && sent < ItemTarget) begin
      set_phase();
      if ($urandom_range(9, 0) == 0) send_cmd(OP_DELETE, pick_value());
      else send_cmd(OP_DELETE, sb.nth_value($urandom_range(sb.used_count - 1, 0)));
    end
  endtask

  task automatic mixed_run();
    repeat ($urandom_range(40, 10)) begin
      set_phase();
      if ($urandom_range(1, 0) == 0) send_cmd(OP_APPEND, pick_value());
      else if (sb.used_count > 0 && $urandom_range(9, 0) < 7)
        send_cmd(OP_DELETE, sb.nth_value($urandom_range(sb.used_count - 1, 0)));
      else send_cmd(OP_DELETE, pick_value());
    end
  endtask

  initial begin
    sb      = new();
    sent    = 0;
    gap_pct = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list, extremes, duplicates, first/last/middle removal
    send_cmd(OP_DELETE, 32'd5);
    send_cmd(OP_APPEND, 32'h7FFF_FFFF);
    send_cmd(OP_APPEND, 32'h8000_0000);
    send_cmd(OP_APPEND, 32'h0000_0000);
    send_cmd(OP_APPEND, 32'hFFFF_FFFF);
    send_cmd(OP_APPEND, 32'hFFFF_FFFF);
    send_cmd(OP_APPEND, 32'h0000_0001);
    send_cmd(OP_DELETE, 32'h8000_0001);
    send_cmd(OP_DELETE, 32'hFFFF_FFFF);
    send_cmd(OP_DELETE, 32'h7FFF_FFFF);
    send_cmd(OP_DELETE, 32'h0000_0001);
    send_cmd(OP_DELETE, 32'd42);
    send_cmd(OP_DELETE, 32'h8000_0000);
    send_cmd(OP_APPEND, 32'h5555_5555);
    send_cmd(OP_APPEND, 32'hAAAA_AAAA);
    send_cmd(OP_DELETE, 32'hFFFF_FFFF);
    send_cmd(OP_DELETE, 32'hFFFF_FFFF);
    send_cmd(OP_DELETE, 32'h0000_0000);
    send_cmd(OP_DELETE, 32'hAAAA_AAAA);
    send_cmd(OP_DELETE, 32'h5555_5555);
    send_cmd(OP_DELETE, 32'h0000_0000);

    fill_store();
    drain_list();
    while (sent < ItemTarget) begin
      case ($urandom_range(9, 0))
        0, 1, 2: fill_store();
        3, 4, 5: drain_list();
        default: mixed_run();
      endcase
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (NODE_COUNT + 8) @(posedge clk);

    $display("commands %0d, results checked %0d, mismatches %0d",
             sent, sb.checked, sb.mismatches);
    $display("appends %0d, full %0d, removals %0d, misses %0d",
             sb.n_appended, sb.n_full, sb.n_removed, sb.n_missed);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // cycles with neither a command nor a result transfer
  initial begin
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transfer in %0d cycles", IdleLimit);
    $display("TB_ERROR");
    $finish;
  end

endmodule
